@@ rtl/lsc_pkg.sv @@
package lsc_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int MAX_CLIP_STEPS_DEF = 8;

  localparam int WINDOW_LEFT_RST   = 0;
  localparam int WINDOW_BOTTOM_RST = 0;
  localparam int WINDOW_RIGHT_RST  = 800;
  localparam int WINDOW_TOP_RST    = 600;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEFT   = 2'd0,
    REG_WINDOW_BOTTOM = 2'd1,
    REG_WINDOW_RIGHT  = 2'd2,
    REG_WINDOW_TOP    = 2'd3
  } cfg_reg_t;

  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef logic [3:0] outcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_CALC,
    ST_EMIT
  } clip_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

@@ rtl/line_segment_window_clip.sv @@
// Channel   Direction  Handshake              Payload
// cfg_      in         cfg_we (no wait)       cfg_index, cfg_wdata
// in_       in         in_valid / in_ready    start_x, start_y, end_x, end_y
// out_      out        out_valid / out_ready  accepted, clipped start and end points
//
// One segment at a time: each is taken and tested, then clipped by up to MAX_CLIP_STEPS
// steps, each followed by a new test, and then handed off.
// Each clip step runs one multiply and a bit-serial restoring divide on the shared
// multiply/divide unit; the divide runs 2*COORD_WIDTH+1 iterations.
// Reset is synchronous; it loads the window defaults and empties the result register.
// A finished result waits in the output register; the next segment is taken meanwhile.
module line_segment_window_clip #(
  parameter int COORD_WIDTH    = lsc_pkg::COORD_WIDTH_DEF,
  parameter int MAX_CLIP_STEPS = lsc_pkg::MAX_CLIP_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic signed [COORD_WIDTH-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_start_x,
  input  logic signed [COORD_WIDTH-1:0]   in_start_y,
  input  logic signed [COORD_WIDTH-1:0]   in_end_x,
  input  logic signed [COORD_WIDTH-1:0]   in_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_start_x,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_start_y,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_end_x,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_end_y
);
  import lsc_pkg::*;

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= W'(WINDOW_LEFT_RST);
      win_bottom_r <= W'(WINDOW_BOTTOM_RST);
      win_right_r  <= W'(WINDOW_RIGHT_RST);
      win_top_r    <= W'(WINDOW_TOP_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LEFT:   win_left_r   <= cfg_wdata;
        REG_WINDOW_BOTTOM: win_bottom_r <= cfg_wdata;
        REG_WINDOW_RIGHT:  win_right_r  <= cfg_wdata;
        REG_WINDOW_TOP:    win_top_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lsc_seq #(
    .COORD_WIDTH    (COORD_WIDTH),
    .MAX_CLIP_STEPS (MAX_CLIP_STEPS)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .win_left            (win_left_r),
    .win_bottom          (win_bottom_r),
    .win_right           (win_right_r),
    .win_top             (win_top_r),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_x          (in_start_x),
    .in_start_y          (in_start_y),
    .in_end_x            (in_end_x),
    .in_end_y            (in_end_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_clipped_start_x (out_clipped_start_x),
    .out_clipped_start_y (out_clipped_start_y),
    .out_clipped_end_x   (out_clipped_end_x),
    .out_clipped_end_y   (out_clipped_end_y)
  );

`ifndef SYNTH
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a segment is in progress");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> (out_clipped_start_x == '0) &&
      (out_clipped_start_y == '0) && (out_clipped_end_x == '0) &&
      (out_clipped_end_y == '0))
    else $error("rejected segment carries nonzero endpoints");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ rtl/lsc_muldiv.sv @@
module lsc_muldiv #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_WIDTH:0]   a_mag,
  input  logic [COORD_WIDTH:0]   b_mag,
  input  logic [COORD_WIDTH:0]   d_mag,
  output logic                   done,
  output logic [COORD_WIDTH-1:0] quotient
);
  import lsc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 1;
  localparam int CW = $clog2(PW + 1);

  md_state_t       state_r, state_nxt;
  logic [W:0]      a_r, b_r, d_r;
  logic [PW-1:0]   quo_r;
  logic [W:0]      rem_r;
  logic [CW-1:0]   cnt_r;
  logic [2*W+1:0]  prod;
  logic [W+1:0]    rem_sh;
  logic [W+1:0]    d_ext;
  logic [W+1:0]    rem_sub;
  logic            ge;
  logic            load_mul;
  logic            div_step;

  assign prod    = a_r * b_r;
  assign rem_sh  = {rem_r, quo_r[PW-1]};
  assign d_ext   = {1'b0, d_r};
  assign ge      = (rem_sh >= d_ext);
  assign rem_sub = rem_sh - d_ext;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  state_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == '0) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    load_mul = (state_r == MD_MUL);
    div_step = (state_r == MD_DIV);
    done     = (state_r == MD_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == MD_IDLE) begin
      a_r <= a_mag;
      b_r <= b_mag;
      d_r <= d_mag;
    end
    if (load_mul) begin
      quo_r <= prod[PW-1:0];
      rem_r <= '0;
      cnt_r <= CW'(PW - 1);
    end else if (div_step) begin
      quo_r <= {quo_r[PW-2:0], ge};
      rem_r <= ge ? rem_sub[W:0] : rem_sh[W:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient = quo_r[W-1:0];

endmodule

@@ rtl/lsc_seq.sv @@
module lsc_seq #(
  parameter int COORD_WIDTH    = lsc_pkg::COORD_WIDTH_DEF,
  parameter int MAX_CLIP_STEPS = lsc_pkg::MAX_CLIP_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [COORD_WIDTH-1:0] win_left,
  input  logic signed [COORD_WIDTH-1:0] win_bottom,
  input  logic signed [COORD_WIDTH-1:0] win_right,
  input  logic signed [COORD_WIDTH-1:0] win_top,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic signed [COORD_WIDTH-1:0] out_clipped_start_x,
  output logic signed [COORD_WIDTH-1:0] out_clipped_start_y,
  output logic signed [COORD_WIDTH-1:0] out_clipped_end_x,
  output logic signed [COORD_WIDTH-1:0] out_clipped_end_y
);
  import lsc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int SW = $clog2(MAX_CLIP_STEPS + 1);

  clip_state_t         state_r, state_nxt;
  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [W-1:0] edge_r;
  logic                axis_y_r, sel2_r, neg_r, ok_r;
  logic [SW-1:0]       steps_r;
  logic                out_valid_r, out_acc_r;
  logic signed [W-1:0] out_x1_r, out_y1_r, out_x2_r, out_y2_r;

  outcode_t            c1, c2, co;
  logic                all_in, reject_now, axis_y, sel2;
  logic signed [W-1:0] edge_val;
  logic signed [W:0]   dx, dy, de, a_d, b_d, c_d;
  logic [W:0]          a_mag, b_mag, c_mag;
  logic                md_start, md_done;
  logic [W-1:0]        md_q;
  logic [W-1:0]        base, new_c;
  logic                ld_in, ld_move, ld_out, out_free;

  function automatic outcode_t f_outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
    outcode_t c;
    c = '0;
    if (x < win_left) c[OC_LEFT] = 1'b1;
    else if (x > win_right) c[OC_RIGHT] = 1'b1;
    if (y < win_bottom) c[OC_BOTTOM] = 1'b1;
    else if (y > win_top) c[OC_TOP] = 1'b1;
    return c;
  endfunction

  function automatic logic [W:0] f_mag(input logic signed [W:0] v);
    return v[W] ? (W+1)'(-v) : (W+1)'(v);
  endfunction

  always_comb begin
    c1       = f_outcode(x1_r, y1_r);
    c2       = f_outcode(x2_r, y2_r);
    sel2     = (c1 == '0);
    co       = sel2 ? c2 : c1;
    axis_y   = co[OC_TOP] | co[OC_BOTTOM];
    edge_val = axis_y ? (co[OC_TOP] ? win_top : win_bottom)
                      : (co[OC_RIGHT] ? win_right : win_left);
    dx       = {x2_r[W-1], x2_r} - {x1_r[W-1], x1_r};
    dy       = {y2_r[W-1], y2_r} - {y1_r[W-1], y1_r};
    de       = axis_y ? ({edge_val[W-1], edge_val} - {y1_r[W-1], y1_r})
                      : ({edge_val[W-1], edge_val} - {x1_r[W-1], x1_r});
    a_d      = axis_y ? dx : dy;
    b_d      = de;
    c_d      = axis_y ? dy : dx;
    a_mag    = f_mag(a_d);
    b_mag    = f_mag(b_d);
    c_mag    = f_mag(c_d);
    all_in   = ((c1 | c2) == '0);
    reject_now = ((c1 & c2) != '0) || (steps_r >= SW'(MAX_CLIP_STEPS)) || (c_mag == '0);
    base     = axis_y_r ? x1_r : y1_r;
    new_c    = neg_r ? (base - md_q) : (base + md_q);
  end

  lsc_muldiv #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (md_start),
    .a_mag    (a_mag),
    .b_mag    (b_mag),
    .d_mag    (c_mag),
    .done     (md_done),
    .quotient (md_q)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_TEST;
      ST_TEST: begin
        if (all_in || reject_now) state_nxt = ST_EMIT;
        else state_nxt = ST_CALC;
      end
      ST_CALC: if (md_done) state_nxt = ST_TEST;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    ld_in    = (state_r == ST_IDLE) && in_valid;
    md_start = (state_r == ST_TEST) && !all_in && !reject_now;
    ld_move  = (state_r == ST_CALC) && md_done;
    ld_out   = (state_r == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      x1_r    <= in_start_x;
      y1_r    <= in_start_y;
      x2_r    <= in_end_x;
      y2_r    <= in_end_y;
      steps_r <= '0;
    end else if (ld_move) begin
      if (sel2_r) begin
        x2_r <= axis_y_r ? new_c : edge_r;
        y2_r <= axis_y_r ? edge_r : new_c;
      end else begin
        x1_r <= axis_y_r ? new_c : edge_r;
        y1_r <= axis_y_r ? edge_r : new_c;
      end
    end
    if (state_r == ST_TEST) begin
      ok_r <= all_in;
    end
    if (md_start) begin
      steps_r  <= steps_r + 1'b1;
      axis_y_r <= axis_y;
      sel2_r   <= sel2;
      edge_r   <= edge_val;
      neg_r    <= a_d[W] ^ b_d[W] ^ c_d[W];
    end
    if (ld_out) begin
      out_acc_r <= ok_r;
      out_x1_r  <= ok_r ? x1_r : '0;
      out_y1_r  <= ok_r ? y1_r : '0;
      out_x2_r  <= ok_r ? x2_r : '0;
      out_y2_r  <= ok_r ? y2_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_clipped_start_x = out_x1_r;
  assign out_clipped_start_y = out_y1_r;
  assign out_clipped_end_x   = out_x2_r;
  assign out_clipped_end_y   = out_y2_r;

endmodule
